// ===== rtl/sorted_set_intersection_unit_macros.svh =====
// Assertion macros shared by the sorted set intersection RTL.
`ifndef SORTED_SET_INTERSECTION_UNIT_MACROS_SVH
`define SORTED_SET_INTERSECTION_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while arst_n is low.
`define SSI_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and disabled while arst_n is low.
`define SSI_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/ssi_pkg.sv =====
// Shared types, codes and constants of the sorted set intersection unit.
package ssi_pkg;

	localparam int unsigned ELEM_W          = 64;
	localparam int unsigned COUNT_W         = 32;
	localparam int unsigned CFG_W           = 4;
	localparam int unsigned DEF_QUEUE_DEPTH = 16;
	localparam int unsigned CMD_FIFO_DEPTH  = 2;
	localparam logic [CFG_W-1:0] ELEM_BYTES_RESET = 4'd4;

	// Request codes on the input channel.
	typedef enum logic [1:0] {
		REQ_ELEM_A = 2'd0,
		REQ_ELEM_B = 2'd1,
		REQ_END_A  = 2'd2,
		REQ_END_B  = 2'd3
	} req_type_t;

	// Result codes on the output channel.
	typedef enum logic [1:0] {
		KIND_MATCH    = 2'd0,
		KIND_DONE     = 2'd1,
		KIND_OVERFLOW = 2'd2
	} kind_t;

	// Classified item passed from the front end to the merge engine.
	typedef struct packed {
		logic              is_b;
		logic              has_elem;
		logic              ends;
		logic              width_ok;
		logic [ELEM_W-1:0] value;
	} cmd_t;

	// Mask that keeps the low nbytes bytes; zero bytes keeps nothing.
	function automatic logic [ELEM_W-1:0] width_mask(input logic [CFG_W-1:0] nbytes);
		logic [ELEM_W-1:0] m;
		m = '0;
		for (int i = 0; i < ELEM_W / 8; i++) begin
			if (CFG_W'(i) < nbytes) begin
				m[i*8 +: 8] = 8'hFF;
			end
		end
		return m;
	endfunction

endpackage

// ===== rtl/ssi_if.sv =====
// Request and result channel interfaces of the sorted set intersection unit.
interface ssi_req_if;
	import ssi_pkg::*;

	logic              valid;
	logic              ready;
	logic [1:0]        req_type;
	logic [ELEM_W-1:0] elem_value;
	logic              is_last;

	modport source (output valid, output req_type, output elem_value, output is_last,
		input ready);
	modport sink (input valid, input req_type, input elem_value, input is_last,
		output ready);
endinterface

interface ssi_rsp_if;
	import ssi_pkg::*;

	logic               valid;
	logic               ready;
	logic [1:0]         kind;
	logic [ELEM_W-1:0]  match_value;
	logic [COUNT_W-1:0] match_count;
	logic               last_of_run;

	modport source (output valid, output kind, output match_value, output match_count,
		output last_of_run, input ready);
	modport sink (input valid, input kind, input match_value, input match_count,
		input last_of_run, output ready);
endinterface

// ===== rtl/ssi_front.sv =====
// Front end: element width register, request decode and value masking.
module ssi_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [ssi_pkg::CFG_W-1:0]  cfg_wdata,
	ssi_req_if.sink                    req,
	output logic                       cmd_valid,
	input  logic                       cmd_ready,
	output ssi_pkg::cmd_t              cmd
);
	import ssi_pkg::*;

	logic [CFG_W-1:0] elem_bytes_q;

	// Element width register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elem_bytes_q <= ELEM_BYTES_RESET;
		end else if (cfg_we) begin
			elem_bytes_q <= cfg_wdata;
		end
	end

	// Decode the request and mask the value to the configured width.
	always_comb begin
		cmd.is_b     = (req.req_type == REQ_ELEM_B) || (req.req_type == REQ_END_B);
		cmd.has_elem = (req.req_type == REQ_ELEM_A) || (req.req_type == REQ_ELEM_B);
		cmd.ends     = cmd.has_elem ? req.is_last : 1'b1;
		cmd.width_ok = (elem_bytes_q != '0) && (elem_bytes_q <= CFG_W'(ELEM_W / 8));
		cmd.value    = req.elem_value & width_mask(elem_bytes_q);
	end

	assign cmd_valid = req.valid;
	assign req.ready = cmd_ready;

endmodule

// ===== rtl/ssi_cmd_fifo.sv =====
// Short queue of classified items between the front end and the merge engine.
module ssi_cmd_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  ssi_pkg::cmd_t in_cmd,
	output logic          out_valid,
	input  logic          out_ready,
	output ssi_pkg::cmd_t out_cmd
);
	import ssi_pkg::*;

	localparam int unsigned PW = (CMD_FIFO_DEPTH > 1) ? $clog2(CMD_FIFO_DEPTH) : 1;
	localparam int unsigned CW = $clog2(CMD_FIFO_DEPTH + 1);

	cmd_t          entry_q [CMD_FIFO_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          push;
	logic          pop;

	assign in_ready  = (count_q != CW'(CMD_FIFO_DEPTH));
	assign out_valid = (count_q != '0);
	assign out_cmd   = entry_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= in_cmd;
		end
	end

	// Pointers and occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(CMD_FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(CMD_FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/ssi_merge.sv =====
// Merge engine: list queue, head compare loop, completion tracking and result register.
`include "sorted_set_intersection_unit_macros.svh"

module ssi_merge #(
	parameter int unsigned QUEUE_DEPTH = ssi_pkg::DEF_QUEUE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_ready,
	input  ssi_pkg::cmd_t cmd,
	ssi_rsp_if.source     rsp
);
	import ssi_pkg::*;

	localparam int unsigned AW = $clog2(QUEUE_DEPTH);
	localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_CMP,
		ST_CHECK,
		ST_EMIT
	} state_t;

	// Only one list can hold elements once the compare loop has settled, so both
	// lists share one ring buffer and side_b_q tells which list it holds.
	logic [ELEM_W-1:0]  mem [QUEUE_DEPTH];
	logic [ELEM_W-1:0]  rdata_q;

	state_t             state_q;
	logic [AW-1:0]      head_q;
	logic [CW-1:0]      fill_q;
	logic               side_b_q;
	logic               ended_a_q;
	logic               ended_b_q;
	logic               finished_q;
	logic [COUNT_W-1:0] matches_q;
	logic [ELEM_W-1:0]  x_q;
	logic               x_b_q;
	logic               width_ok_q;
	logic               pend_ev_q;
	kind_t              ev_kind_q;
	logic [ELEM_W-1:0]  ev_value_q;
	logic [COUNT_W-1:0] ev_count_q;
	logic               pend_done_q;
	logic [COUNT_W-1:0] done_count_q;
	logic               out_valid_q;
	kind_t              out_kind_q;
	logic [ELEM_W-1:0]  out_value_q;
	logic [COUNT_W-1:0] out_count_q;
	logic               out_last_q;

	logic               own_ended;
	logic               other_held;
	logic               push_now;
	logic [AW-1:0]      head_next;
	logic [AW:0]        tail_sum;
	logic [AW-1:0]      tail;
	logic [COUNT_W-1:0] matches_inc;
	logic               done_now;
	logic               out_free;
	logic               out_load;
	logic               mem_we;
	logic [AW-1:0]      mem_waddr;
	logic [ELEM_W-1:0]  mem_wdata;

	// Decode of the item at the queue head and ring arithmetic.
	always_comb begin
		own_ended  = cmd.is_b ? ended_b_q : ended_a_q;
		other_held = (fill_q != '0) && (side_b_q != cmd.is_b);
		push_now   = (state_q == ST_IDLE) && cmd_valid && !own_ended && !finished_q &&
			cmd.has_elem && !other_held && (fill_q != CW'(QUEUE_DEPTH));
		head_next  = (head_q == AW'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
		tail_sum   = {1'b0, head_q} + {1'b0, fill_q[AW-1:0]};
		tail       = (tail_sum >= (AW+1)'(QUEUE_DEPTH)) ?
			AW'(tail_sum - (AW+1)'(QUEUE_DEPTH)) : tail_sum[AW-1:0];
		matches_inc = (matches_q == '1) ? matches_q : matches_q + 1'b1;
		done_now   = (ended_a_q && (fill_q == '0 || side_b_q)) ||
			(ended_b_q && (fill_q == '0 || !side_b_q));
	end

	// Queue write port: a plain push, or the arriving element that outlived
	// every head of the other list.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = tail;
		mem_wdata = cmd.value;
		if (push_now) begin
			mem_we = 1'b1;
		end else if (state_q == ST_CMP && width_ok_q && x_q > rdata_q &&
				fill_q == CW'(1)) begin
			mem_we    = 1'b1;
			mem_waddr = head_next;
			mem_wdata = x_q;
		end
	end

	// Queue storage with registered head read.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (state_q == ST_LOAD) begin
			rdata_q <= mem[head_q];
		end
	end

	assign cmd_ready = (state_q == ST_IDLE);
	assign out_free  = !out_valid_q || rsp.ready;
	assign out_load  = (state_q == ST_EMIT) && out_free && (pend_ev_q || pend_done_q);

	// Sequencer and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			head_q       <= '0;
			fill_q       <= '0;
			side_b_q     <= 1'b0;
			ended_a_q    <= 1'b0;
			ended_b_q    <= 1'b0;
			finished_q   <= 1'b0;
			matches_q    <= '0;
			x_q          <= '0;
			x_b_q        <= 1'b0;
			width_ok_q   <= 1'b0;
			pend_ev_q    <= 1'b0;
			ev_kind_q    <= KIND_MATCH;
			ev_value_q   <= '0;
			ev_count_q   <= '0;
			pend_done_q  <= 1'b0;
			done_count_q <= '0;
			out_valid_q  <= 1'b0;
			out_kind_q   <= KIND_MATCH;
			out_value_q  <= '0;
			out_count_q  <= '0;
			out_last_q   <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (cmd_valid && !own_ended) begin
						if (finished_q) begin
							// After completion only the end of the remaining list matters.
							if (cmd.ends) begin
								if (cmd.is_b ? ended_a_q : ended_b_q) begin
									ended_a_q  <= 1'b0;
									ended_b_q  <= 1'b0;
									finished_q <= 1'b0;
									matches_q  <= '0;
								end else if (cmd.is_b) begin
									ended_b_q <= 1'b1;
								end else begin
									ended_a_q <= 1'b1;
								end
							end
						end else begin
							x_q        <= cmd.value;
							x_b_q      <= cmd.is_b;
							width_ok_q <= cmd.width_ok;
							if (cmd.ends) begin
								if (cmd.is_b) begin
									ended_b_q <= 1'b1;
								end else begin
									ended_a_q <= 1'b1;
								end
							end
							if (cmd.has_elem && other_held) begin
								state_q <= ST_LOAD;
							end else begin
								if (cmd.has_elem) begin
									if (fill_q == CW'(QUEUE_DEPTH)) begin
										pend_ev_q  <= 1'b1;
										ev_kind_q  <= KIND_OVERFLOW;
										ev_value_q <= '0;
										ev_count_q <= matches_q;
									end else begin
										fill_q   <= fill_q + 1'b1;
										side_b_q <= cmd.is_b;
									end
								end
								state_q <= ST_CHECK;
							end
						end
					end
				end

				ST_LOAD: begin
					state_q <= ST_CMP;
				end

				ST_CMP: begin
					// Compare the new element with the head of the other list.
					priority if (!width_ok_q || x_q == rdata_q) begin
						head_q <= head_next;
						fill_q <= fill_q - 1'b1;
						if (width_ok_q) begin
							matches_q  <= matches_inc;
							pend_ev_q  <= 1'b1;
							ev_kind_q  <= KIND_MATCH;
							ev_value_q <= x_q;
							ev_count_q <= matches_inc;
						end
						state_q <= ST_CHECK;
					end else if (x_q < rdata_q) begin
						state_q <= ST_CHECK;
					end else begin
						head_q <= head_next;
						if (fill_q == CW'(1)) begin
							// Last head gone: the new element now fills its own list.
							side_b_q <= x_b_q;
							state_q  <= ST_CHECK;
						end else begin
							fill_q  <= fill_q - 1'b1;
							state_q <= ST_LOAD;
						end
					end
				end

				ST_CHECK: begin
					// A list that has ended with nothing queued completes the pair.
					if (done_now) begin
						pend_done_q  <= 1'b1;
						done_count_q <= matches_q;
						head_q       <= '0;
						fill_q       <= '0;
						if (ended_a_q && ended_b_q) begin
							ended_a_q  <= 1'b0;
							ended_b_q  <= 1'b0;
							matches_q  <= '0;
						end else begin
							finished_q <= 1'b1;
						end
					end
					state_q <= (done_now || pend_ev_q) ? ST_EMIT : ST_IDLE;
				end

				ST_EMIT: begin
					if (out_free) begin
						if (pend_ev_q) begin
							out_kind_q  <= ev_kind_q;
							out_value_q <= ev_value_q;
							out_count_q <= ev_count_q;
							out_last_q  <= !pend_done_q;
							pend_ev_q   <= 1'b0;
							if (!pend_done_q) begin
								state_q <= ST_IDLE;
							end
						end else begin
							out_kind_q  <= KIND_DONE;
							out_value_q <= '0;
							out_count_q <= done_count_q;
							out_last_q  <= 1'b1;
							pend_done_q <= 1'b0;
							state_q     <= ST_IDLE;
						end
					end
				end

				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.kind        = out_kind_q;
	assign rsp.match_value = out_value_q;
	assign rsp.match_count = out_count_q;
	assign rsp.last_of_run = out_last_q;

	// Both lists ended always clears the pair before the next item is taken.
	`SSI_ASSERT_IMP(a_idle_not_both_ended, state_q == ST_IDLE, !(ended_a_q && ended_b_q), "both lists ended while idle")
	// A completed pair keeps nothing queued.
	`SSI_ASSERT_IMP(a_finished_empty, finished_q, fill_q == '0, "queue holds elements after completion")
	// A compare needs a head of the list opposite to the arriving element.
	`SSI_ASSERT_IMP(a_cmp_other_list, state_q == ST_CMP, (fill_q != '0) && (side_b_q != x_b_q), "compare without a head of the other list")
	// The result register is never overwritten while a result waits.
	`SSI_ASSERT_IMP(a_out_no_overwrite, out_load, !out_valid_q || rsp.ready, "result overwritten before it was taken")
	// Completion leaves the pair finished or fully cleared.
	`SSI_ASSERT_NXT(a_done_marks_finished, state_q == ST_CHECK && done_now, finished_q || (!ended_a_q && !ended_b_q), "completion did not mark the pair finished")

endmodule

// ===== rtl/sorted_set_intersection_unit.sv =====
// Sorted set intersection unit top level.
//
// Elements of two ascending lists arrive on req, each tagged A or B, and are
// masked to the configured element width; matches, completion and overflow
// results leave on rsp. An item is first classified and placed in a
// two-entry queue, so the input can run ahead while the merge engine works or
// while a result waits to be taken, until that queue is full. The merge engine
// takes an item in its idle state and then checks for completion; an item that
// meets queued heads of the other list first passes through a read of the list
// memory, then a compare, for every head that it is compared against, and each
// result is handed to the output register in an emit step that waits while the
// register is full. The single read port of the list memory paces the compare
// loop. Over a whole list pair each element is compared about once. The list
// memory holds QUEUE_DEPTH elements and needs no clearing after reset.
module sorted_set_intersection_unit #(
	parameter int unsigned QUEUE_DEPTH = ssi_pkg::DEF_QUEUE_DEPTH
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [ssi_pkg::CFG_W-1:0] cfg_wdata,
	ssi_req_if.sink                   req,
	ssi_rsp_if.source                 rsp
);
	import ssi_pkg::*;

	logic front_valid;
	logic front_ready;
	cmd_t front_cmd;
	logic merge_valid;
	logic merge_ready;
	cmd_t merge_cmd;

	// Request decode and element width register.
	ssi_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req),
		.cmd_valid (front_valid),
		.cmd_ready (front_ready),
		.cmd       (front_cmd)
	);

	// Decoupling queue.
	ssi_cmd_fifo u_cmd_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (front_valid),
		.in_ready  (front_ready),
		.in_cmd    (front_cmd),
		.out_valid (merge_valid),
		.out_ready (merge_ready),
		.out_cmd   (merge_cmd)
	);

	// Merge engine and result register.
	ssi_merge #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (merge_valid),
		.cmd_ready (merge_ready),
		.cmd       (merge_cmd),
		.rsp       (rsp)
	);

endmodule
